// ----- rtl/core/sltab_pkg.sv -----
package sltab_pkg;

    // List geometry.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COORD_W  = 16;
    localparam int PAIR_W   = 2 * COORD_W;
    localparam int CMD_W    = 3;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PRED   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SUCC   = 3'd6;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MOVE,
        ST_PUT,
        ST_SCAN,
        ST_NEXT,
        ST_DONE
    } state_t;

    // One command word as it enters the engine.
    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [IDX_W-1:0]  pos;
        logic [PAIR_W-1:0] key;
    } cmd_t;

    // One result word as it leaves the engine.
    typedef struct packed {
        logic              ok;
        logic [PAIR_W-1:0] pair;
        logic [IDX_W-1:0]  fidx;
        logic [CNT_W-1:0]  len;
        logic              empty;
    } res_t;

endpackage

// ----- rtl/core/sltab_ram.sv -----
module sltab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, read every cycle.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/core/sltab_engine.sv -----
module sltab_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sltab_pkg::cmd_t   cmd,
    output logic              busy,
    output logic              res_vld,
    input  logic              res_take,
    output sltab_pkg::res_t   res
);

    localparam logic [sltab_pkg::CNT_W-1:0] CAP_CNT =
        sltab_pkg::CNT_W'(sltab_pkg::CAPACITY);
    localparam logic [sltab_pkg::CNT_W-1:0] ONE_CNT = sltab_pkg::CNT_W'(1);
    localparam logic [sltab_pkg::IDX_W-1:0] ONE_IDX = sltab_pkg::IDX_W'(1);

    sltab_pkg::state_t state_reg, state_next;

    logic [sltab_pkg::CMD_W-1:0]  op_reg, op_next;
    logic [sltab_pkg::IDX_W-1:0]  pos_reg, pos_next;
    logic [sltab_pkg::PAIR_W-1:0] key_reg, key_next;
    logic [sltab_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [sltab_pkg::CNT_W-1:0]  ptr_reg, ptr_next;
    logic                         iss_reg, iss_next;
    logic                         pend_reg, pend_next;
    logic [sltab_pkg::IDX_W-1:0]  pidx_reg, pidx_next;
    logic [sltab_pkg::PAIR_W-1:0] prev_reg, prev_next;
    logic                         ok_reg, ok_next;
    logic [sltab_pkg::PAIR_W-1:0] pair_reg, pair_next;
    logic [sltab_pkg::IDX_W-1:0]  fidx_reg, fidx_next;

    logic                         wr_en;
    logic [sltab_pkg::IDX_W-1:0]  wr_addr;
    logic [sltab_pkg::PAIR_W-1:0] wr_data;
    logic [sltab_pkg::IDX_W-1:0]  rd_addr;
    logic [sltab_pkg::PAIR_W-1:0] rd_data;
    logic                         key_hit;
    logic                         move_last;
    logic [sltab_pkg::CNT_W-1:0]  pos_ext;

    // Entry store: one write and one registered read per cycle.
    sltab_ram #(
        .WIDTH (sltab_pkg::PAIR_W),
        .DEPTH (sltab_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare unit: the entry just read against the search key.
    assign key_hit = (rd_data == key_reg);

    // The read address comes from the new word at start, else from the walk pointer.
    assign rd_addr = (state_reg == sltab_pkg::ST_IDLE) ? cmd.pos
                                                       : ptr_reg[sltab_pkg::IDX_W-1:0];

    assign pos_ext = {1'b0, pos_reg};

    // Insert walks down to the target slot; delete walks up to the tail.
    assign move_last = (op_reg == sltab_pkg::CMD_INSERT)
                       ? (ptr_reg == pos_ext)
                       : (ptr_reg == cnt_reg - ONE_CNT);

    assign busy    = (state_reg != sltab_pkg::ST_IDLE);
    assign res_vld = (state_reg == sltab_pkg::ST_DONE);

    always_comb
    begin
        res.ok    = ok_reg;
        res.pair  = pair_reg;
        res.fidx  = fidx_reg;
        res.len   = cnt_reg;
        res.empty = (cnt_reg == '0);
    end

    // Sequencer state and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sltab_pkg::ST_IDLE;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            iss_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ptr_reg   <= ptr_next;
            iss_reg   <= iss_next;
            pend_reg  <= pend_next;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        pos_reg  <= pos_next;
        key_reg  <= key_next;
        pidx_reg <= pidx_next;
        prev_reg <= prev_next;
        ok_reg   <= ok_next;
        pair_reg <= pair_next;
        fidx_reg <= fidx_next;
    end

    // Next state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        ptr_next   = ptr_reg;
        iss_next   = iss_reg;
        pend_next  = pend_reg;
        pidx_next  = pidx_reg;
        prev_next  = prev_reg;
        ok_next    = ok_reg;
        pair_next  = pair_reg;
        fidx_next  = fidx_reg;
        wr_en      = 1'b0;
        wr_addr    = pidx_reg;
        wr_data    = rd_data;

        case (state_reg)
            sltab_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.op;
                    pos_next   = cmd.pos;
                    key_next   = cmd.key;
                    ok_next    = 1'b0;
                    pair_next  = '0;
                    fidx_next  = '0;
                    pend_next  = 1'b0;
                    state_next = sltab_pkg::ST_DONE;
                    case (cmd.op)
                        sltab_pkg::CMD_CLEAR:
                        begin
                            cnt_next = '0;
                            ok_next  = 1'b1;
                        end
                        sltab_pkg::CMD_INSERT:
                        begin
                            if (cnt_reg < CAP_CNT && {1'b0, cmd.pos} <= cnt_reg)
                            begin
                                if ({1'b0, cmd.pos} == cnt_reg)
                                begin
                                    // Append: nothing to move.
                                    state_next = sltab_pkg::ST_PUT;
                                end
                                else
                                begin
                                    ptr_next   = cnt_reg - ONE_CNT;
                                    iss_next   = 1'b1;
                                    state_next = sltab_pkg::ST_MOVE;
                                end
                            end
                        end
                        sltab_pkg::CMD_DELETE,
                        sltab_pkg::CMD_READ:
                        begin
                            if ({1'b0, cmd.pos} < cnt_reg)
                            begin
                                state_next = sltab_pkg::ST_READ;
                            end
                        end
                        sltab_pkg::CMD_LOCATE,
                        sltab_pkg::CMD_PRED,
                        sltab_pkg::CMD_SUCC:
                        begin
                            if (cnt_reg != '0)
                            begin
                                ptr_next   = '0;
                                state_next = sltab_pkg::ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = sltab_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            sltab_pkg::ST_READ:
            begin
                // The addressed entry is on the read port now.
                pair_next  = rd_data;
                ok_next    = 1'b1;
                state_next = sltab_pkg::ST_DONE;
                if (op_reg == sltab_pkg::CMD_DELETE)
                begin
                    if (pos_ext + ONE_CNT < cnt_reg)
                    begin
                        ptr_next   = pos_ext + ONE_CNT;
                        iss_next   = 1'b1;
                        state_next = sltab_pkg::ST_MOVE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - ONE_CNT;
                    end
                end
            end

            sltab_pkg::ST_MOVE:
            begin
                // Write back the entry read last cycle one slot over.
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = (op_reg == sltab_pkg::CMD_INSERT) ? pidx_reg + ONE_IDX
                                                                : pidx_reg - ONE_IDX;
                end
                // Read the next source entry while the write goes on.
                if (iss_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[sltab_pkg::IDX_W-1:0];
                    if (move_last)
                    begin
                        iss_next = 1'b0;
                    end
                    else if (op_reg == sltab_pkg::CMD_INSERT)
                    begin
                        ptr_next = ptr_reg - ONE_CNT;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + ONE_CNT;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (op_reg == sltab_pkg::CMD_INSERT)
                    begin
                        state_next = sltab_pkg::ST_PUT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - ONE_CNT;
                        state_next = sltab_pkg::ST_DONE;
                    end
                end
            end

            sltab_pkg::ST_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = key_reg;
                cnt_next   = cnt_reg + ONE_CNT;
                ok_next    = 1'b1;
                state_next = sltab_pkg::ST_DONE;
            end

            sltab_pkg::ST_SCAN:
            begin
                // Keep one read in flight ahead of the compare.
                if (ptr_reg < cnt_reg)
                begin
                    ptr_next  = ptr_reg + ONE_CNT;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[sltab_pkg::IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && key_hit)
                begin
                    state_next = sltab_pkg::ST_DONE;
                    case (op_reg)
                        sltab_pkg::CMD_LOCATE:
                        begin
                            ok_next   = 1'b1;
                            fidx_next = pidx_reg;
                        end
                        sltab_pkg::CMD_PRED:
                        begin
                            if (pidx_reg != '0)
                            begin
                                ok_next   = 1'b1;
                                pair_next = prev_reg;
                                fidx_next = pidx_reg;
                            end
                        end
                        default:
                        begin
                            // Successor: the following entry is already being read.
                            if ({1'b0, pidx_reg} + ONE_CNT < cnt_reg)
                            begin
                                fidx_next  = pidx_reg;
                                state_next = sltab_pkg::ST_NEXT;
                            end
                        end
                    endcase
                end
                else
                begin
                    if (pend_reg)
                    begin
                        prev_next = rd_data;
                    end
                    if (ptr_reg >= cnt_reg)
                    begin
                        // Last entry compared without a match.
                        state_next = sltab_pkg::ST_DONE;
                    end
                end
            end

            sltab_pkg::ST_NEXT:
            begin
                pend_next  = 1'b0;
                pair_next  = rd_data;
                ok_next    = 1'b1;
                state_next = sltab_pkg::ST_DONE;
            end

            sltab_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = sltab_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sltab_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/sequential_list_table_core.sv -----
// Steps: clear and rejected commands go straight to the output word; read fetches the entry;
// delete fetches it and shifts the later entries down a slot; insert shifts the entries from
// the tail to the position up a slot, then writes the pair; searches scan from the front.
// Throughput: one word at a time; the entry walk moves one entry per cycle through the
// single read port and single write port of the entry store.
// Reset: asynchronous, active low; the list is empty and no output word is pending.
module sequential_list_table_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sltab_pkg::CMD_W-1:0]          command,
    input  logic [sltab_pkg::IDX_W-1:0]          position,
    input  logic signed [sltab_pkg::COORD_W-1:0] coord_x,
    input  logic signed [sltab_pkg::COORD_W-1:0] coord_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 ok,
    output logic signed [sltab_pkg::COORD_W-1:0] out_x,
    output logic signed [sltab_pkg::COORD_W-1:0] out_y,
    output logic [sltab_pkg::IDX_W-1:0]          found_index,
    output logic [sltab_pkg::CNT_W-1:0]          list_length,
    output logic                                 is_empty
);

    sltab_pkg::cmd_t cmd;
    sltab_pkg::res_t res;
    sltab_pkg::res_t res_out_reg;
    logic            start;
    logic            busy;
    logic            res_vld;
    logic            res_load;
    logic            out_valid_reg, out_valid_next;

    // Input word.
    assign start    = in_valid && !in_stall;
    assign in_stall = busy;

    always_comb
    begin
        cmd.op  = command;
        cmd.pos = position;
        cmd.key = {coord_x, coord_y};
    end

    sltab_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .busy     (busy),
        .res_vld  (res_vld),
        .res_take (res_load),
        .res      (res)
    );

    // Output register: loads when empty or when its word is taken.
    assign res_load       = res_vld && (!out_valid_reg || !out_stall);
    assign out_valid_next = res_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = res_out_reg.ok;
    assign out_x       = res_out_reg.pair[sltab_pkg::PAIR_W-1:sltab_pkg::COORD_W];
    assign out_y       = res_out_reg.pair[sltab_pkg::COORD_W-1:0];
    assign found_index = res_out_reg.fidx;
    assign list_length = res_out_reg.len;
    assign is_empty    = res_out_reg.empty;

    // An accepted word keeps the engine busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> in_stall)
        else $error("engine not busy after an accepted word");

    // A finished result is never shown while the engine still takes input.
    a_done_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld |-> in_stall)
        else $error("input accepted while a result is pending");

    // The reported length stays within capacity and agrees with the empty flag.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (list_length <= sltab_pkg::CNT_W'(sltab_pkg::CAPACITY))
                      && (is_empty == (list_length == '0)))
        else $error("list length out of range or empty flag wrong");

    // A failed command returns no pair and no index.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (out_x == '0) && (out_y == '0) && (found_index == '0))
        else $error("failed command returned a pair or an index");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    // The command code that the block leaves unused.
    localparam logic [sltab_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_WORDS = 1200;
    localparam int DRAIN_CYCLES = 40;

    // One input word as it waits to be driven.
    typedef struct packed {
        logic [sltab_pkg::CMD_W-1:0]   op;
        logic [sltab_pkg::IDX_W-1:0]   pos;
        logic [sltab_pkg::COORD_W-1:0] x;
        logic [sltab_pkg::COORD_W-1:0] y;
    } list_word_t;

    // One result word as the list should answer it.
    typedef struct packed {
        logic                          ok;
        logic [sltab_pkg::COORD_W-1:0] x;
        logic [sltab_pkg::COORD_W-1:0] y;
        logic [sltab_pkg::IDX_W-1:0]   fidx;
        logic [sltab_pkg::CNT_W-1:0]   len;
        logic                          empty;
    } list_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [sltab_pkg::CMD_W-1:0]          command = '0;
    logic [sltab_pkg::IDX_W-1:0]          position = '0;
    logic signed [sltab_pkg::COORD_W-1:0] coord_x = '0;
    logic signed [sltab_pkg::COORD_W-1:0] coord_y = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 ok;
    logic signed [sltab_pkg::COORD_W-1:0] out_x;
    logic signed [sltab_pkg::COORD_W-1:0] out_y;
    logic [sltab_pkg::IDX_W-1:0]          found_index;
    logic [sltab_pkg::CNT_W-1:0]          list_length;
    logic                                 is_empty;

    // Words still to be driven and results still to arrive.
    list_word_t   pending_words[$];
    list_result_t expected_results[$];

    // The list as it should stand after every accepted word.
    logic [sltab_pkg::PAIR_W-1:0] list_mem [sltab_pkg::CAPACITY];
    int                           list_len = 0;

    int mismatch_count = 0;
    int result_index = 0;

    // Sender bursts and receiver stall pattern.
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_run = 0;
    int stall_phase = 0;

    sequential_list_table_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .position    (position),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .out_x       (out_x),
        .out_y       (out_y),
        .found_index (found_index),
        .list_length (list_length),
        .is_empty    (is_empty)
    );

    always #10 clk = ~clk;

    // Apply one command to the list and return the answer it should give.
    function automatic list_result_t apply_command(
        input logic [sltab_pkg::CMD_W-1:0]  op,
        input logic [sltab_pkg::IDX_W-1:0]  pos,
        input logic [sltab_pkg::PAIR_W-1:0] key
    );
        list_result_t                 res;
        logic [sltab_pkg::PAIR_W-1:0] pair;
        int                           hit;
        int                           k;
        res = '0;
        pair = '0;
        hit = -1;
        // Searches report the first equal pair only.
        for (k = 0; k < list_len; k++)
        begin
            if (hit < 0 && list_mem[sltab_pkg::IDX_W'(k)] == key)
                hit = k;
        end
        case (op)
            sltab_pkg::CMD_CLEAR:
            begin
                list_len = 0;
                res.ok = 1'b1;
            end
            sltab_pkg::CMD_INSERT:
            begin
                if (list_len < sltab_pkg::CAPACITY && pos <= list_len)
                begin
                    for (k = list_len; k > pos; k--)
                        list_mem[sltab_pkg::IDX_W'(k)] = list_mem[sltab_pkg::IDX_W'(k - 1)];
                    list_mem[pos] = key;
                    list_len++;
                    res.ok = 1'b1;
                end
            end
            sltab_pkg::CMD_DELETE:
            begin
                if (pos < list_len)
                begin
                    pair = list_mem[pos];
                    for (k = pos + 1; k < list_len; k++)
                        list_mem[sltab_pkg::IDX_W'(k - 1)] = list_mem[sltab_pkg::IDX_W'(k)];
                    list_len--;
                    res.ok = 1'b1;
                end
            end
            sltab_pkg::CMD_READ:
            begin
                if (pos < list_len)
                begin
                    pair = list_mem[pos];
                    res.ok = 1'b1;
                end
            end
            sltab_pkg::CMD_LOCATE:
            begin
                if (hit >= 0)
                begin
                    res.fidx = sltab_pkg::IDX_W'(hit);
                    res.ok = 1'b1;
                end
            end
            sltab_pkg::CMD_PRED:
            begin
                if (hit > 0)
                begin
                    pair = list_mem[sltab_pkg::IDX_W'(hit - 1)];
                    res.fidx = sltab_pkg::IDX_W'(hit);
                    res.ok = 1'b1;
                end
            end
            sltab_pkg::CMD_SUCC:
            begin
                if (hit >= 0 && hit + 1 < list_len)
                begin
                    pair = list_mem[sltab_pkg::IDX_W'(hit + 1)];
                    res.fidx = sltab_pkg::IDX_W'(hit);
                    res.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.x = pair[sltab_pkg::PAIR_W-1:sltab_pkg::COORD_W];
        res.y = pair[sltab_pkg::COORD_W-1:0];
        res.len = sltab_pkg::CNT_W'(list_len);
        res.empty = (list_len == 0);
        return res;
    endfunction

    task automatic queue_word(
        input logic [sltab_pkg::CMD_W-1:0]   op,
        input logic [sltab_pkg::IDX_W-1:0]   pos,
        input logic [sltab_pkg::COORD_W-1:0] x,
        input logic [sltab_pkg::COORD_W-1:0] y
    );
        list_word_t word;
        word.op = op;
        word.pos = pos;
        word.x = x;
        word.y = y;
        pending_words.push_back(word);
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR: result word %0d: %s", result_index, what);
        mismatch_count++;
    endtask

    // Sender: drive queued words in bursts, hold a word while it is stalled,
    // and predict each word at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin : sender
        list_word_t word;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= '0;
            position <= '0;
            coord_x <= '0;
            coord_y <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(apply_command(command, position, {coord_x, coord_y}));
            if (in_valid && in_stall)
            begin
                // The stalled word stays on the ports.
            end
            else if (gap_left > 0 || pending_words.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                word = pending_words.pop_front();
                command <= word.op;
                position <= word.pos;
                coord_x <= word.x;
                coord_y <= word.y;
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: check each accepted result word and stall on a changing pattern.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        list_result_t want;
        logic         stall_next;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            mode_left <= 0;
            stall_run <= 0;
            stall_phase <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result word with no command waiting for it");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (ok !== want.ok)
                        report_mismatch($sformatf("ok got %b expected %b", ok, want.ok));
                    if (out_x !== want.x)
                        report_mismatch($sformatf("out_x got %h expected %h", out_x, want.x));
                    if (out_y !== want.y)
                        report_mismatch($sformatf("out_y got %h expected %h", out_y, want.y));
                    if (found_index !== want.fidx)
                        report_mismatch($sformatf("found_index got %0d expected %0d",
                                                  found_index, want.fidx));
                    if (list_length !== want.len)
                        report_mismatch($sformatf("list_length got %0d expected %0d",
                                                  list_length, want.len));
                    if (is_empty !== want.empty)
                        report_mismatch($sformatf("is_empty got %b expected %b",
                                                  is_empty, want.empty));
                end
                result_index <= result_index + 1;
            end

            // Pick a new stall pattern every so often; long stalls are cut short.
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 150);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 3) == 0);
                2: stall_next = ($urandom_range(0, 9) < 6);
                default: stall_next = (stall_phase % 3 == 0);
            endcase
            if (stall_run >= 8)
                stall_next = 1'b0;
            out_stall <= stall_next;
            stall_run <= stall_next ? stall_run + 1 : 0;
            stall_phase <= stall_phase + 1;
        end
    end

    // Stimulus, reset and the end of the run.
    initial
    begin
        logic [sltab_pkg::PAIR_W-1:0]  key_pool [8];
        logic [sltab_pkg::PAIR_W-1:0]  key;
        logic [sltab_pkg::CMD_W-1:0]   op;
        logic [sltab_pkg::IDX_W-1:0]   pos;
        logic                          growing;
        int                            gen_len;
        int                            roll;
        int                            n;

        // Empty list: the read, delete, locate and an insert past the end must be refused.
        queue_word(sltab_pkg::CMD_CLEAR, 4'd0, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_READ, 4'd0, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_DELETE, 4'd0, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_LOCATE, 4'd0, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_INSERT, 4'd1, 16'h1234, 16'h5678);

        // Build four entries using the coordinate extremes.
        queue_word(sltab_pkg::CMD_INSERT, 4'd0, 16'h8000, 16'h7fff);
        queue_word(sltab_pkg::CMD_INSERT, 4'd1, 16'h7fff, 16'h8000);
        queue_word(sltab_pkg::CMD_INSERT, 4'd0, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_INSERT, 4'd1, 16'hffff, 16'hffff);

        // Searches: hit, partial match, neighbors at both ends and inside.
        queue_word(sltab_pkg::CMD_LOCATE, 4'd0, 16'hffff, 16'hffff);
        queue_word(sltab_pkg::CMD_LOCATE, 4'd0, 16'hffff, 16'h0000);
        queue_word(sltab_pkg::CMD_PRED, 4'd0, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_PRED, 4'd0, 16'h8000, 16'h7fff);
        queue_word(sltab_pkg::CMD_SUCC, 4'd0, 16'h7fff, 16'h8000);
        queue_word(sltab_pkg::CMD_SUCC, 4'd0, 16'h0000, 16'h0000);

        // Reads and removals at and past the length, and the unused code.
        queue_word(sltab_pkg::CMD_READ, 4'd3, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_READ, 4'd4, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_DELETE, 4'd4, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_INSERT, 4'd15, 16'h4321, 16'h8765);
        queue_word(CMD_UNUSED, 4'd15, 16'hffff, 16'hffff);
        queue_word(sltab_pkg::CMD_DELETE, 4'd1, 16'h0000, 16'h0000);
        queue_word(sltab_pkg::CMD_DELETE, 4'd0, 16'h0000, 16'h0000);

        // A duplicate pair: searches must report the first one.
        queue_word(sltab_pkg::CMD_INSERT, 4'd2, 16'h8000, 16'h7fff);
        queue_word(sltab_pkg::CMD_LOCATE, 4'd0, 16'h8000, 16'h7fff);
        queue_word(sltab_pkg::CMD_SUCC, 4'd0, 16'h8000, 16'h7fff);

        // Random part: the list length is tracked so that most positions are
        // in range, and keys come mostly from a small pool so searches hit.
        key_pool[0] = {16'h8000, 16'h7fff};
        key_pool[1] = {16'h7fff, 16'h8000};
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (n = 4; n < 8; n++)
            key_pool[3'(n)] = $urandom;
        gen_len = 3;
        growing = 1'b0;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            // Alternate between filling the list and draining it.
            if (n % 60 == 0)
                growing = !growing;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                op = growing ? sltab_pkg::CMD_READ : sltab_pkg::CMD_CLEAR;
            else if (roll < 4)
                op = CMD_UNUSED;
            else if (roll < 50)
                op = growing ? sltab_pkg::CMD_INSERT : sltab_pkg::CMD_DELETE;
            else if (roll < 58)
                op = growing ? sltab_pkg::CMD_DELETE : sltab_pkg::CMD_INSERT;
            else if (roll < 70)
                op = sltab_pkg::CMD_READ;
            else if (roll < 80)
                op = sltab_pkg::CMD_LOCATE;
            else if (roll < 90)
                op = sltab_pkg::CMD_PRED;
            else
                op = sltab_pkg::CMD_SUCC;

            if ($urandom_range(0, 4) == 0
                || (op == sltab_pkg::CMD_INSERT && gen_len >= sltab_pkg::CAPACITY))
                pos = sltab_pkg::IDX_W'($urandom_range(0, sltab_pkg::CAPACITY - 1));
            else if (op == sltab_pkg::CMD_INSERT)
                pos = sltab_pkg::IDX_W'($urandom_range(0, gen_len));
            else if (gen_len > 0)
                pos = sltab_pkg::IDX_W'($urandom_range(0, gen_len - 1));
            else
                pos = '0;

            roll = $urandom_range(0, 9);
            if (roll < 7)
                key = key_pool[3'($urandom_range(0, 7))];
            else if (roll < 8)
                key = {key_pool[3'($urandom_range(0, 7))][sltab_pkg::PAIR_W-1:sltab_pkg::COORD_W],
                       16'($urandom)};
            else
                key = $urandom;
            queue_word(op, pos, key[sltab_pkg::PAIR_W-1:sltab_pkg::COORD_W],
                       key[sltab_pkg::COORD_W-1:0]);

            if (op == sltab_pkg::CMD_CLEAR)
                gen_len = 0;
            else if (op == sltab_pkg::CMD_INSERT && gen_len < sltab_pkg::CAPACITY
                     && pos <= gen_len)
                gen_len++;
            else if (op == sltab_pkg::CMD_DELETE && pos < gen_len)
                gen_len--;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every word to go in and every result to come out.
        while (pending_words.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Run limit, well beyond the slowest correct run.
    initial
    begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/sltab_pkg.sv
rtl/core/sltab_ram.sv
rtl/core/sltab_engine.sv
rtl/core/sequential_list_table_core.sv
tb/sv/testbench.sv
